/* hdl/efc_pkg.sv */
// efc_pkg: shared types, constants and helper functions for the edge/face
// connectivity builder (hash table entry, memory request, result record)
// no dependencies
package efc_pkg;

  // block sizes
  localparam int FACE_CAPACITY = 4096;
  localparam int NODE_ID_BITS  = 16;
  localparam int ELEMENT_LIMIT = 65536;

  // port field widths
  localparam int CORNER_BITS   = 16;
  localparam int ELEM_OUT_BITS = 16;
  localparam int FACE_OUT_BITS = 12;

  // derived widths
  localparam int KEY_BITS      = 2 * NODE_ID_BITS;
  localparam int FACE_ID_BITS  = (FACE_CAPACITY > 1) ? $clog2(FACE_CAPACITY) : 1;
  localparam int FACE_CNT_BITS = $clog2(FACE_CAPACITY + 1);
  localparam int ELEM_BITS     = $clog2(ELEMENT_LIMIT);
  // hash table has at least twice as many slots as faces, so a probe
  // always ends at a hit or a free slot
  localparam int TBL_BITS      = FACE_ID_BITS + 1;
  localparam int TBL_DEPTH     = 1 << TBL_BITS;
  localparam int HASH_CHUNKS   = (KEY_BITS + TBL_BITS - 1) / TBL_BITS;

  typedef logic [NODE_ID_BITS-1:0]  node_t;
  typedef logic [KEY_BITS-1:0]      key_t;
  typedef logic [TBL_BITS-1:0]      tbl_addr_t;
  typedef logic [FACE_ID_BITS-1:0]  face_id_t;
  typedef logic [FACE_CNT_BITS-1:0] face_cnt_t;
  typedef logic [ELEM_BITS-1:0]     elem_cnt_t;

  localparam face_cnt_t FACE_CAP_CNT = FACE_CNT_BITS'(FACE_CAPACITY);
  localparam elem_cnt_t ELEM_LAST    = ELEM_BITS'(ELEMENT_LIMIT - 1);

  // local edge corner pairs: 0-1, 1-2, 2-3, 3-0
  localparam logic [1:0] EDGE_P [4] = '{2'd0, 2'd1, 2'd2, 2'd3};
  localparam logic [1:0] EDGE_Q [4] = '{2'd1, 2'd2, 2'd3, 2'd0};
  localparam logic [1:0] LAST_EDGE  = 2'd3;

  // one hash table slot
  typedef struct packed {
    logic     valid;
    key_t     key;
    face_id_t face;
  } entry_t;

  // request from the sequencer to the table memory
  typedef struct packed {
    logic      rd_en;
    tbl_addr_t rd_addr;
    logic      wr_en;
    tbl_addr_t wr_addr;
    entry_t    wdata;
  } ram_req_t;

  // one finished element
  typedef struct packed {
    logic [ELEM_OUT_BITS-1:0]       element_index;
    logic [3:0][FACE_OUT_BITS-1:0]  face_id;
    logic [3:0]                     is_new;
    logic                           overflow;
  } result_t;

  // corner id reduced to the node id width
  function automatic node_t node_of(input logic [CORNER_BITS-1:0] corner);
    return NODE_ID_BITS'(corner);
  endfunction

  // edge key: smaller id in the upper half, larger id in the lower half
  function automatic key_t make_key(input node_t p, input node_t q);
    node_t lo;
    node_t hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    return {lo, hi};
  endfunction

  // xor fold of the key down to a table address
  function automatic tbl_addr_t edge_hash(input key_t key);
    logic [HASH_CHUNKS*TBL_BITS-1:0] padded;
    tbl_addr_t h;
    padded = (HASH_CHUNKS*TBL_BITS)'(key);
    h = '0;
    for (int i = 0; i < HASH_CHUNKS; i++) begin
      h = h ^ padded[i*TBL_BITS +: TBL_BITS];
    end
    return h;
  endfunction

endpackage

/* hdl/efc_edge_ram.sv */
// efc_edge_ram: simple dual-port edge hash table, one write and one
// registered read per cycle (read returns old data on a same-address write)
// depends on efc_pkg
module efc_edge_ram import efc_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rdata
);

  entry_t mem [TBL_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

/* hdl/efc_engine.sv */
// efc_engine: per-element sequencer; clears the table after reset, then runs
// four lookup-or-insert probe sequences per element against the edge hash table
// depends on efc_pkg and efc_edge_ram
module efc_engine import efc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CORNER_BITS-1:0] corner [4],
  output logic                   res_valid,
  input  logic                   res_take,
  output result_t                res
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  state_t    state;
  tbl_addr_t clr_addr;
  node_t     node [4];
  logic [1:0] edge_idx;
  key_t      cur_key;
  tbl_addr_t probe_addr;
  logic      bypass;
  entry_t    byp_entry;
  face_cnt_t face_cnt;
  elem_cnt_t elem_cnt;

  ram_req_t  req;
  entry_t    rdata;
  entry_t    look;
  logic      hit;
  logic      empty;
  logic      room;
  logic      advance;
  logic [1:0] nxt_edge;
  key_t      key0;
  key_t      nxt_key;
  tbl_addr_t nxt_hash;

  efc_edge_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // slot compare, with the just-written entry forwarded when addresses met
  always_comb begin
    look     = bypass ? byp_entry : rdata;
    hit      = look.valid && (look.key == cur_key);
    empty    = !look.valid;
    room     = face_cnt < FACE_CAP_CNT;
    advance  = (state == S_PROBE) && (hit || empty);
    nxt_edge = edge_idx + 2'd1;
    key0     = make_key(node_of(corner[0]), node_of(corner[1]));
    nxt_key  = make_key(node[EDGE_P[nxt_edge]], node[EDGE_Q[nxt_edge]]);
    nxt_hash = edge_hash(nxt_key);
  end

  // memory requests
  always_comb begin
    req = '0;
    unique case (state)
      S_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = clr_addr;
        req.wdata   = '0;
      end
      S_IDLE: begin
        req.rd_en   = in_valid;
        req.rd_addr = edge_hash(key0);
      end
      S_PROBE: begin
        // insert into the free slot
        if (empty && room) begin
          req.wr_en       = 1'b1;
          req.wr_addr     = probe_addr;
          req.wdata.valid = 1'b1;
          req.wdata.key   = cur_key;
          req.wdata.face  = FACE_ID_BITS'(face_cnt);
        end
        // next slot of this edge, or first slot of the next edge
        if (!hit && !empty) begin
          req.rd_en   = 1'b1;
          req.rd_addr = probe_addr + 1'b1;
        end else if (edge_idx != LAST_EDGE) begin
          req.rd_en   = 1'b1;
          req.rd_addr = nxt_hash;
        end
      end
      S_DONE: begin
        req = '0;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // sequencer state, counters and result record
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      face_cnt <= '0;
      elem_cnt <= '0;
      bypass   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < 4; i++) begin
              node[i] <= node_of(corner[i]);
            end
            edge_idx          <= '0;
            cur_key           <= key0;
            probe_addr        <= edge_hash(key0);
            bypass            <= 1'b0;
            res.overflow      <= 1'b0;
            res.element_index <= ELEM_OUT_BITS'(elem_cnt);
            elem_cnt          <= (elem_cnt == ELEM_LAST) ? '0 : elem_cnt + 1'b1;
            state             <= S_PROBE;
          end
        end
        S_PROBE: begin
          bypass <= 1'b0;
          if (hit) begin
            res.face_id[edge_idx] <= FACE_OUT_BITS'(look.face);
            res.is_new[edge_idx]  <= 1'b0;
          end else if (empty) begin
            if (room) begin
              res.face_id[edge_idx] <= FACE_OUT_BITS'(face_cnt);
              res.is_new[edge_idx]  <= 1'b1;
              face_cnt              <= face_cnt + 1'b1;
            end else begin
              res.face_id[edge_idx] <= '0;
              res.is_new[edge_idx]  <= 1'b0;
              res.overflow          <= 1'b1;
            end
          end else begin
            probe_addr <= probe_addr + 1'b1;
          end
          // move to the next local edge
          if (advance) begin
            if (edge_idx == LAST_EDGE) begin
              state <= S_DONE;
            end else begin
              edge_idx   <= nxt_edge;
              cur_key    <= nxt_key;
              probe_addr <= nxt_hash;
              bypass     <= req.wr_en && (req.wr_addr == nxt_hash);
              byp_entry  <= req.wdata;
            end
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/edge_face_connectivity_builder.sv */
// edge_face_connectivity_builder: top level with stream ports and the
// output beat register
// depends on efc_pkg and efc_engine
//
// Each input beat is one quad element; each output beat gives the element
// index and the face number and new flag of each of its edges 0-1, 1-2, 2-3,
// 3-0, plus an overflow flag once all faces are allocated. Edges live in an
// open-addressed hash table in one dual-port memory with twice as many slots
// as faces. An element is accepted, probed edge by edge, with one more
// probe for each collision, and its result is then handed to the output
// register. After reset the block sweeps the table once, one slot per cycle,
// before it takes the first beat. A result waiting in the output register
// lets the next element in; that element's result then waits in the engine.
module edge_face_connectivity_builder import efc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // corner_a, corner_b, corner_c, corner_d
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // element_index, face_id_0..3, is_new_0..3, overflow, 3 zero bits
  output logic [71:0] m_axis_tdata
);

  logic [CORNER_BITS-1:0] corner [4];
  logic    res_valid;
  logic    res_take;
  result_t res;
  result_t out_res;

  // unpack corner ids
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      corner[i] = s_axis_tdata[i*CORNER_BITS +: CORNER_BITS];
    end
  end

  efc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .corner    (corner),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output beat register
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (res_take) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {3'b000, out_res.overflow, out_res.is_new,
                         out_res.face_id[3], out_res.face_id[2],
                         out_res.face_id[1], out_res.face_id[0],
                         out_res.element_index};

  // one element in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new element accepted while one is in progress");

  // a blocked result stays put in the engine
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("pending result changed before handoff");

  // overflow only comes with an edge that got no face
  a_overflow_edge: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.overflow) |->
      ((out_res.face_id[0] == '0 && !out_res.is_new[0]) ||
       (out_res.face_id[1] == '0 && !out_res.is_new[1]) ||
       (out_res.face_id[2] == '0 && !out_res.is_new[2]) ||
       (out_res.face_id[3] == '0 && !out_res.is_new[3])))
    else $error("overflow flagged without an unallocated edge");

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for edge_face_connectivity_builder; predicts the face
// numbers of every quad from its own edge table and compares each output beat
// depends on efc_pkg and edge_face_connectivity_builder
module tb;
  import efc_pkg::*;

  localparam int RANDOM_ITEMS   = 1570;
  localparam int AFTER_FULL_MIN = 250;
  localparam int TAIL_ITEMS     = 64;
  localparam int GRID_SPAN      = 16;
  localparam int GRID_PITCH     = 64;
  localparam int GRID_BASE      = 16'h4000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RUN_LIMIT      = 48_000_000;

  // one output beat: element_index in the low bits, overflow on top
  typedef struct packed {
    logic                          overflow;
    logic [3:0]                    is_new;
    logic [3:0][FACE_OUT_BITS-1:0] face_id;
    logic [ELEM_OUT_BITS-1:0]      element_index;
  } quad_faces_t;

  // edge table copy plus the queue of face results still owed by the block
  class edge_face_tracker;
    int unsigned face_of_edge [key_t];
    int unsigned faces_used;
    int unsigned elem_count;
    quad_faces_t pending_faces[$];
    int unsigned errors;
    int unsigned element_total;
    int unsigned matched_edges;
    int unsigned overflow_elements;

    // work out the faces of one accepted quad and queue them
    function void note_element(input logic [63:0] beat);
      node_t       corner [4];
      node_t       p;
      node_t       q;
      node_t       lo;
      node_t       hi;
      key_t        key;
      quad_faces_t want;
      want = '0;
      want.element_index = ELEM_OUT_BITS'(elem_count);
      for (int k = 0; k < 4; k++) begin
        corner[k] = beat[k*CORNER_BITS +: NODE_ID_BITS];
      end
      for (int e = 0; e < 4; e++) begin
        p = corner[EDGE_P[e]];
        q = corner[EDGE_Q[e]];
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        key = {lo, hi};
        if (face_of_edge.exists(key)) begin
          want.face_id[e] = FACE_OUT_BITS'(face_of_edge[key]);
          matched_edges++;
        end else if (faces_used < FACE_CAPACITY) begin
          face_of_edge[key] = faces_used;
          want.face_id[e] = FACE_OUT_BITS'(faces_used);
          want.is_new[e] = 1'b1;
          faces_used++;
        end else begin
          want.overflow = 1'b1;
        end
      end
      if (want.overflow) overflow_elements++;
      pending_faces.insert(pending_faces.size(), want);
      element_total++;
      elem_count++;
      if (elem_count >= ELEMENT_LIMIT) elem_count = 0;
    endfunction

    // compare one output beat with the oldest queued element
    function void check_result(input logic [71:0] beat);
      quad_faces_t got;
      quad_faces_t want;
      if (pending_faces.size() == 0) begin
        $error("output beat with no element outstanding: %h", beat);
        errors++;
        return;
      end
      want = pending_faces.pop_front();
      got = beat[$bits(quad_faces_t)-1:0];
      if (got.element_index !== want.element_index) begin
        $error("element_index: expected %0d, got %0d", want.element_index, got.element_index);
        errors++;
      end
      for (int e = 0; e < 4; e++) begin
        if (got.face_id[e] !== want.face_id[e]) begin
          $error("face_id_%0d: expected %0d, got %0d", e, want.face_id[e], got.face_id[e]);
          errors++;
        end
        if (got.is_new[e] !== want.is_new[e]) begin
          $error("is_new_%0d: expected %0d, got %0d", e, want.is_new[e], got.is_new[e]);
          errors++;
        end
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        errors++;
      end
      if (beat[71:$bits(quad_faces_t)] !== '0) begin
        $error("pad bits: expected 0, got %b", beat[71:$bits(quad_faces_t)]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // corner_a, corner_b, corner_c, corner_d
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // element_index, face_id_0..3, is_new_0..3, overflow, 3 zero bits
  logic [71:0] m_axis_tdata;

  bit               idle_on;
  logic [63:0]      sent_quads[$];
  edge_face_tracker faces = new();

  edge_face_connectivity_builder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("run limit reached with %0d elements outstanding", faces.pending_faces.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output side: random stall bursts while idling is on
  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // output beat monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) faces.check_result(m_axis_tdata);
  end

  // drive one quad beat and wait for it to be taken, then maybe a gap
  task automatic send_beat(input logic [63:0] beat);
    int gap;
    s_axis_tdata  <= beat;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    faces.note_element(beat);
    sent_quads.insert(sent_quads.size(), beat);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // same quad, random starting corner and winding; the edge set is unchanged
  function automatic logic [63:0] turn_quad(input logic [63:0] beat);
    logic [127:0] twice;
    logic [63:0]  turned;
    int           shift;
    twice = {beat, beat};
    shift = $urandom_range(0, 3);
    turned = twice[16*shift +: 64];
    if ($urandom_range(0, 1) == 1)
      turned = {turned[15:0], turned[31:16], turned[47:32], turned[63:48]};
    return turned;
  endfunction

  // stimulus
  initial begin
    int          n;
    int          after_full;
    int          pick;
    int          fresh_share;
    int          gi;
    int          gj;
    bit          full;
    logic [15:0] nc [4];
    logic [63:0] beat;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_on       = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: sharing, winding, degenerate edges, id extremes
    send_beat({16'd4, 16'd3, 16'd2, 16'd1});
    send_beat({16'd3, 16'd6, 16'd5, 16'd2});
    send_beat({16'd1, 16'd2, 16'd3, 16'd4});
    send_beat({16'd2, 16'd1, 16'd4, 16'd3});
    send_beat({16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_beat({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_beat({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    send_beat({16'd9, 16'd8, 16'd7, 16'd7});
    send_beat({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    send_beat({16'hFFFE, 16'h0001, 16'h0000, 16'hFFFF});
    send_beat({16'd4, 16'd3, 16'd2, 16'd1});
    send_beat({16'd4, 16'd8, 16'd9, 16'd1});
    send_beat({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});

    // random: fill the table with mostly fresh quads, then mostly mesh quads
    n = 0;
    after_full = 0;
    while (n < RANDOM_ITEMS || after_full < AFTER_FULL_MIN) begin
      if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      full = (faces.faces_used >= FACE_CAPACITY);
      fresh_share = full ? 10 : 75;
      pick = $urandom_range(0, 99);
      if (pick < fresh_share) begin
        beat = {$urandom, $urandom};
      end else if (pick < fresh_share + 5) begin
        // noise: extremes and repeated corners
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(0, 3))
            0: nc[k] = 16'h0000;
            1: nc[k] = 16'hFFFF;
            2: nc[k] = 16'($urandom);
            default: nc[k] = (k == 0) ? 16'h0000 : nc[k-1];
          endcase
        end
        beat = {nc[3], nc[2], nc[1], nc[0]};
      end else if (pick < fresh_share + 15) begin
        beat = turn_quad(sent_quads[$urandom_range(0, sent_quads.size() - 1)]);
      end else begin
        // cell of a structured patch, neighbors share edges
        gi = $urandom_range(0, GRID_SPAN - 1);
        gj = $urandom_range(0, GRID_SPAN - 1);
        nc[0] = 16'(GRID_BASE + gi * GRID_PITCH + gj);
        nc[1] = 16'(nc[0] + 16'd1);
        nc[2] = 16'(nc[0] + 16'(GRID_PITCH) + 16'd1);
        nc[3] = 16'(nc[0] + 16'(GRID_PITCH));
        beat = turn_quad({nc[3], nc[2], nc[1], nc[0]});
      end
      send_beat(beat);
      n++;
      if (full) after_full++;
    end

    // last part, no idling: earlier quads again, back to back
    idle_on = 1'b0;
    repeat (TAIL_ITEMS) begin
      send_beat(turn_quad(sent_quads[$urandom_range(0, sent_quads.size() - 1)]));
    end
    s_axis_tvalid <= 1'b0;

    while (faces.pending_faces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d quads sent, %0d faces allocated, %0d edge matches", faces.element_total,
             faces.faces_used, faces.matched_edges);
    $display("%0d elements met a full face table, with stalls on both sides",
             faces.overflow_elements);
    if (faces.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/efc_pkg.sv
hdl/efc_edge_ram.sv
hdl/efc_engine.sv
hdl/edge_face_connectivity_builder.sv
verif/tb.sv
